// ===== rtl/core/ffa_pkg.sv =====
// Package for the first-fit free-list allocator: word types, request and
// status codes, table sizing. No dependencies.
package ffa_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [31:0] RoundAdd  = 32'h0000_0fff;
  localparam logic [31:0] RoundMask = 32'hffff_f000;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_TOTAL = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_LOST    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] block_size;
    logic [31:0] block_addr;
    logic        round_4k;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [6:0]  entries_used;
    logic [6:0]  peak_entries;
    logic [31:0] lost_count;
    logic [31:0] lost_bytes;
  } out_word_t;

  // table memory port, driven by the sequencer
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [31:0]     wstart;
    logic [31:0]     wlen;
    logic [IdxW-1:0] raddr;
  } mem_ctl_t;

endpackage

// ===== rtl/core/ffa_table.sv =====
// Range table memory: start/length pairs, one write and one registered read.
// Depends on ffa_pkg.
module ffa_table (
  input  logic                  clk,
  input  ffa_pkg::mem_ctl_t     ctl,
  output logic [31:0]           rd_start,
  output logic [31:0]           rd_len
);

  logic [63:0] mem [ffa_pkg::TableDepth];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= {ctl.wstart, ctl.wlen};
    end
    {rd_start, rd_len} <= mem[ctl.raddr];
  end

endmodule

// ===== rtl/core/ffa_seq.sv =====
// Sequencer: scans, shifts and updates the range table one entry per step.
// Depends on ffa_pkg; drives ffa_table.
module ffa_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ffa_pkg::in_word_t     req,
  input  logic [31:0]           rd_start,
  input  logic [31:0]           rd_len,
  output ffa_pkg::mem_ctl_t     ctl,
  output logic                  busy,
  output logic                  done,
  output ffa_pkg::out_word_t    res
);

  localparam int unsigned IW = ffa_pkg::IdxW;
  localparam int unsigned CW = ffa_pkg::CntW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_CHK    = 9'b000000100,
    S_RMV    = 9'b000001000,
    S_INS    = 9'b000010000,
    S_PREV   = 9'b000100000,
    S_NEXT   = 9'b001000000,
    S_FINAL  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, peak_r, peak_nxt;
  logic [31:0] dcnt_r, dcnt_nxt, dbytes_r, dbytes_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] size_r, size_nxt, addr_r, addr_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] pst_r, pst_nxt, plen_r, plen_nxt;
  logic        phave_r, phave_nxt;
  // rmv phase: low reads entry k_r, high writes it to slot k_r-1
  logic        shift_up_r, shift_up_nxt;
  logic [31:0] hs_r, hs_nxt, hl_r, hl_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [31:0] rsize;
  logic [31:0] ssum;

  assign rsize = (req.round_4k && req.req_type != ffa_pkg::REQ_TOTAL) ?
                 ((req.block_size + ffa_pkg::RoundAdd) & ffa_pkg::RoundMask) :
                 req.block_size;
  assign ssum  = pst_r + plen_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; peak_nxt = peak_r;
    dcnt_nxt = dcnt_r; dbytes_nxt = dbytes_r; k_nxt = k_r; op_nxt = op_r;
    size_nxt = size_r; addr_nxt = addr_r; acc_nxt = acc_r; st_nxt = st_r;
    pst_nxt = pst_r; plen_nxt = plen_r; phave_nxt = phave_r;
    shift_up_nxt = shift_up_r; hs_nxt = hs_r; hl_nxt = hl_r; pos_nxt = pos_r;
    ctl = '0;
    ctl.raddr = k_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = req.req_type; size_nxt = rsize; addr_nxt = req.block_addr;
          acc_nxt = '0; st_nxt = ffa_pkg::ST_OK; k_nxt = '0; phave_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // read issued for k_r, or finish the scan
        if (op_r == ffa_pkg::REQ_NONE) begin
          state_nxt = S_DONE;
        end else if (k_r >= cnt_r) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        unique case (op_r)
          ffa_pkg::REQ_TOTAL: begin
            acc_nxt = acc_r + rd_len; k_nxt = k_r + 1'b1; state_nxt = S_RD;
          end
          ffa_pkg::REQ_ALLOC: begin
            if (rd_len >= size_r) begin
              acc_nxt = rd_start;
              if (rd_len == size_r) begin
                state_nxt = S_RMV; k_nxt = k_r + 1'b1;
              end else begin
                ctl.we = 1'b1; ctl.waddr = k_r[IW-1:0];
                ctl.wstart = rd_start + size_r; ctl.wlen = rd_len - size_r;
                state_nxt = S_DONE;
              end
            end else begin
              k_nxt = k_r + 1'b1; state_nxt = S_RD;
            end
          end
          default: begin
            // free: find first start > addr
            if (rd_start > addr_r) begin
              pos_nxt = k_r; hs_nxt = rd_start; hl_nxt = rd_len;
              state_nxt = S_PREV;
            end else begin
              pst_nxt = rd_start; plen_nxt = rd_len; phave_nxt = 1'b1;
              k_nxt = k_r + 1'b1; state_nxt = S_RD;
            end
          end
        endcase
      end
      S_FINAL: begin
        // scan ran off the end
        if (op_r == ffa_pkg::REQ_ALLOC) begin
          st_nxt = ffa_pkg::ST_NOFIT; acc_nxt = '0; state_nxt = S_DONE;
        end else if (op_r == ffa_pkg::REQ_FREE) begin
          pos_nxt = cnt_r; state_nxt = S_PREV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PREV: begin
        // merge decisions; successor held in hs/hl when pos < cnt
        if (phave_r && ssum == addr_r) begin
          if (pos_r < cnt_r && addr_r + size_r == hs_r) begin
            ctl.we = 1'b1; ctl.waddr = IW'(pos_r - 1'b1);
            ctl.wstart = pst_r; ctl.wlen = plen_r + size_r + hl_r;
            k_nxt = pos_r + 1'b1; state_nxt = S_RMV;
          end else begin
            ctl.we = 1'b1; ctl.waddr = IW'(pos_r - 1'b1);
            ctl.wstart = pst_r; ctl.wlen = plen_r + size_r;
            state_nxt = S_DONE;
          end
        end else if (pos_r < cnt_r && addr_r + size_r == hs_r) begin
          ctl.we = 1'b1; ctl.waddr = pos_r[IW-1:0];
          ctl.wstart = addr_r; ctl.wlen = hl_r + size_r;
          state_nxt = S_DONE;
        end else if (cnt_r < CW'(ffa_pkg::TableDepth)) begin
          k_nxt = cnt_r; state_nxt = S_INS;
          ctl.raddr = IW'(cnt_r - 1'b1);
        end else begin
          dcnt_nxt = dcnt_r + 1'b1; dbytes_nxt = dbytes_r + size_r;
          st_nxt = ffa_pkg::ST_LOST; state_nxt = S_DONE;
        end
      end
      S_INS: begin
        // k_r: slot to fill; read data holds entry k_r-1
        if (k_r == pos_r) begin
          ctl.we = 1'b1; ctl.waddr = k_r[IW-1:0];
          ctl.wstart = addr_r; ctl.wlen = size_r;
          cnt_nxt = cnt_r + 1'b1;
          if (peak_r < cnt_r + 1'b1) peak_nxt = cnt_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          ctl.we = 1'b1; ctl.waddr = k_r[IW-1:0];
          ctl.wstart = rd_start; ctl.wlen = rd_len;
          k_nxt = k_r - 1'b1;
          ctl.raddr = IW'(k_r - 2'd2);
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        state_nxt = S_INS;
        ctl.raddr = IW'(k_r - 1'b1);
      end
      S_RMV: begin
        // k_r: source index; two phases per entry: read entry k_r, then write it to k_r-1
        if (k_r >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1; state_nxt = S_DONE;
        end else begin
          shift_up_nxt = ~shift_up_r;
          if (!shift_up_r) begin
            ctl.raddr = k_r[IW-1:0];
          end else begin
            ctl.we = 1'b1; ctl.waddr = IW'(k_r - 1'b1);
            ctl.wstart = rd_start; ctl.wlen = rd_len;
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; peak_r <= '0;
      dcnt_r <= '0; dbytes_r <= '0; shift_up_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; peak_r <= peak_nxt;
      dcnt_r <= dcnt_nxt; dbytes_r <= dbytes_nxt;
      shift_up_r <= (state_nxt == S_RMV) ? shift_up_nxt : 1'b0;
    end
    k_r <= k_nxt; op_r <= op_nxt; size_r <= size_nxt; addr_r <= addr_nxt;
    acc_r <= acc_nxt; st_r <= st_nxt; pst_r <= pst_nxt; plen_r <= plen_nxt;
    phave_r <= phave_nxt; hs_r <= hs_nxt; hl_r <= hl_nxt; pos_r <= pos_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

  always_comb begin
    res.value        = (op_r == ffa_pkg::REQ_ALLOC || op_r == ffa_pkg::REQ_TOTAL) ?
                       acc_r : '0;
    res.status       = st_r;
    res.entries_used = 7'(cnt_r);
    res.peak_entries = 7'(peak_r);
    res.lost_count   = dcnt_r;
    res.lost_bytes   = dbytes_r;
  end

endmodule

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator: handshake, output register.
// Depends on ffa_pkg, ffa_seq, ffa_table.
//
//   channel  dir  word        handshake
//   in_      in   in_word_t   in_valid / in_stall
//   out_     out  out_word_t  out_valid / out_stall
//
// One request at a time. The single table read port sets the pace: the
// scan reads one entry per S_RD/S_CHK pair, removal shifts one entry per
// read and write phase of S_RMV, insert one entry per S_INS/S_NEXT pair.
// Synchronous active-low reset empties the table at once. in_stall is high
// while a request is in work or a result waits in the output register.
module first_fit_free_list_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffa_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffa_pkg::out_word_t  out_data
);

  ffa_pkg::mem_ctl_t  ctl;
  ffa_pkg::out_word_t res;
  logic [31:0] rd_start, rd_len;
  logic busy, done, start;

  assign in_stall = busy | out_valid;
  assign start    = in_valid & ~in_stall;

  ffa_seq u_seq (
    .clk, .rst_n, .start, .req(in_data), .rd_start, .rd_len,
    .ctl, .busy, .done, .res
  );

  ffa_table u_table (.clk, .ctl, .rd_start, .rd_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (done) out_data <= res;
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for first_fit_free_list_allocator: a predictor of the
// free-range table checks every result word in order. Depends on ffa_pkg.
`timescale 1ns / 100ps

module tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ffa_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ffa_pkg::out_word_t out_data;

  first_fit_free_list_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] fl_start [ffa_pkg::TableDepth];
  logic [31:0] fl_len [ffa_pkg::TableDepth];
  int unsigned fl_cnt, fl_peak;
  logic [31:0] drop_cnt, drop_bytes;

  ffa_pkg::in_word_t  req_q [$];
  ffa_pkg::out_word_t want_q [$];
  int unsigned errors, n_sent, n_seen, n_lost, n_nofit;
  bit quiet_end;
  bit in_acc = 1'b0;
  int unsigned hold_cnt;

  function automatic void fl_remove(input int unsigned p);
    for (int unsigned k = p; k + 1 < fl_cnt; k++) begin
      fl_start[k] = fl_start[k+1];
      fl_len[k] = fl_len[k+1];
    end
    fl_cnt--;
  endfunction

  function automatic ffa_pkg::out_word_t predict_request(input ffa_pkg::in_word_t w);
    ffa_pkg::out_word_t r;
    logic [31:0] sz, a;
    int unsigned p;
    bit done;
    r = '0;
    sz = w.block_size;
    a = w.block_addr;
    done = 0;
    if (w.round_4k && w.req_type != ffa_pkg::REQ_TOTAL)
      sz = (sz + ffa_pkg::RoundAdd) & ffa_pkg::RoundMask;
    case (ffa_pkg::req_t'(w.req_type))
      ffa_pkg::REQ_ALLOC: begin
        r.status = ffa_pkg::ST_NOFIT;
        for (int unsigned k = 0; k < fl_cnt && !done; k++) begin
          if (fl_len[k] >= sz) begin
            r.value = fl_start[k];
            r.status = ffa_pkg::ST_OK;
            fl_start[k] += sz;
            fl_len[k] -= sz;
            if (fl_len[k] == 0) fl_remove(k);
            done = 1;
          end
        end
      end
      ffa_pkg::REQ_FREE: begin
        p = 0;
        while (p < fl_cnt && fl_start[p] <= a) p++;
        if (p > 0 && fl_start[p-1] + fl_len[p-1] == a) begin
          fl_len[p-1] += sz;
          if (p < fl_cnt && a + sz == fl_start[p]) begin
            fl_len[p-1] += fl_len[p];
            fl_remove(p);
          end
        end else if (p < fl_cnt && a + sz == fl_start[p]) begin
          fl_start[p] = a;
          fl_len[p] += sz;
        end else if (fl_cnt < ffa_pkg::TableDepth) begin
          for (int unsigned k = fl_cnt; k > p; k--) begin
            fl_start[k] = fl_start[k-1];
            fl_len[k] = fl_len[k-1];
          end
          fl_cnt++;
          if (fl_peak < fl_cnt) fl_peak = fl_cnt;
          fl_start[p] = a;
          fl_len[p] = sz;
        end else begin
          drop_cnt++;
          drop_bytes += sz;
          r.status = ffa_pkg::ST_LOST;
        end
      end
      ffa_pkg::REQ_TOTAL: begin
        for (int unsigned k = 0; k < fl_cnt; k++) r.value += fl_len[k];
      end
      default: ;
    endcase
    r.entries_used = fl_cnt[6:0];
    r.peak_entries = fl_peak[6:0];
    r.lost_count = drop_cnt;
    r.lost_bytes = drop_bytes;
    return r;
  endfunction

  function automatic ffa_pkg::in_word_t mk(input ffa_pkg::req_t t,
                                           input logic [31:0] sz,
                                           input logic [31:0] a, input bit rnd);
    ffa_pkg::in_word_t w;
    w.req_type = t;
    w.block_size = sz;
    w.block_addr = a;
    w.round_4k = rnd;
    return w;
  endfunction

  // driver
  int unsigned in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet_end && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  int unsigned out_gap;
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet_end && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 14);
    end
  end

  // input capture and monitor
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      want_q.push_back(predict_request(in_data));
      n_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, out_data);
      end else begin
        ffa_pkg::out_word_t e;
        e = want_q.pop_front();
        if (e.status == ffa_pkg::ST_LOST) n_lost++;
        if (e.status == ffa_pkg::ST_NOFIT) n_nofit++;
        if (out_data.value !== e.value)
          $display("%0t: value exp %h got %h", $time, e.value, out_data.value);
        if (out_data.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
        if (out_data.entries_used !== e.entries_used)
          $display("%0t: entries_used exp %0d got %0d", $time, e.entries_used,
                   out_data.entries_used);
        if (out_data.peak_entries !== e.peak_entries)
          $display("%0t: peak_entries exp %0d got %0d", $time, e.peak_entries,
                   out_data.peak_entries);
        if (out_data.lost_count !== e.lost_count)
          $display("%0t: lost_count exp %h got %h", $time, e.lost_count,
                   out_data.lost_count);
        if (out_data.lost_bytes !== e.lost_bytes)
          $display("%0t: lost_bytes exp %h got %h", $time, e.lost_bytes,
                   out_data.lost_bytes);
        if (out_data !== e) errors++;
      end
    end
  end

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid || want_q.size() > 0) @(posedge clk);
  endtask

  function automatic ffa_pkg::in_word_t rand_request();
    int unsigned sel;
    logic [31:0] sz, a;
    bit rnd;
    sel = $urandom_range(0, 99);
    rnd = 1'($urandom_range(0, 1));
    // mostly small ranges at page-aligned addresses in a compact window so merges happen
    if ($urandom_range(0, 9) == 0) sz = $urandom();
    else sz = $urandom_range(0, 8) << $urandom_range(0, 12);
    if ($urandom_range(0, 9) == 0) a = $urandom();
    else a = $urandom_range(0, 255) << 12;
    if (sel < 40) return mk(ffa_pkg::REQ_ALLOC, sz, a, rnd);
    if (sel < 85) return mk(ffa_pkg::REQ_FREE, sz, a, rnd);
    if (sel < 97) return mk(ffa_pkg::REQ_TOTAL, $urandom(), $urandom(), rnd);
    return mk(ffa_pkg::REQ_NONE, $urandom(), $urandom(), rnd);
  endfunction

  initial begin
    fl_cnt = 0; fl_peak = 0; drop_cnt = '0; drop_bytes = '0;
    in_gap = 0; out_gap = 0; hold_cnt = 0; quiet_end = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, rounding, merges, table overflow
    req_q.push_back(mk(ffa_pkg::REQ_ALLOC, 32'd0, 32'd0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_TOTAL, '1, '1, 1'b1));
    req_q.push_back(mk(ffa_pkg::REQ_NONE, '1, '1, 1'b1));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h1000, 32'h0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_ALLOC, 32'h10, 32'h0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_ALLOC, 32'd0, 32'h0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h10, 32'h0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h1000, 32'h3000, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h1, 32'h2000, 1'b1));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'hffff_f001, 32'h8000, 1'b1));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h0, 32'h9000, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h100, 32'hffff_ff00, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_ALLOC, 32'hffff_ffff, 32'h0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_ALLOC, 32'h1, 32'h0, 1'b1));
    req_q.push_back(mk(ffa_pkg::REQ_TOTAL, 32'h0, 32'h0, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_ALLOC, 32'h1000, '1, 1'b0));
    wait_drained();
    // fill the table past its depth with isolated ranges
    for (int i = 0; i < ffa_pkg::TableDepth + 3; i++)
      req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'h10 + i, 32'h4000_0000 + i * 32'h100,
                         1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_FREE, 32'hffff_ffff, 32'h7000_0000, 1'b0));
    req_q.push_back(mk(ffa_pkg::REQ_TOTAL, 32'h0, 32'h0, 1'b0));
    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 20; i++) req_q.push_back(rand_request());
    hold_cnt = 300;
    wait (hold_cnt == 0);
    wait_drained();
    for (int i = 0; i < 80; i++)
      req_q.push_back(mk(ffa_pkg::REQ_ALLOC, $urandom_range(1, 64), 32'h0, 1'b0));

    for (int i = 0; i < 420; i++) begin
      req_q.push_back(rand_request());
      if (i == 300) begin
        wait_drained();
        quiet_end = 1;
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d no-fit, %0d lost frees), peak %0d.",
             n_sent, n_seen, n_nofit, n_lost, fl_peak);
    if (errors == 0 && want_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
